@@ design/vmlc_pkg.sv @@
// ----------------------------------------------------------------------------
// vmlc_pkg
// types and limits shared by the mode line clamp modules
// ----------------------------------------------------------------------------
package vmlc_pkg;

    localparam int IN_W = 16;
    localparam int H_W  = 13;
    localparam int V_W  = 12;

    // horizontal register caps, multiples of the 8 pixel character clock
    localparam logic [H_W-1:0] H_DISP_CAP   = 13'd4072;
    localparam logic [H_W-1:0] H_SSTART_CAP = 13'd4080;
    localparam logic [H_W-1:0] H_SEND_CAP   = 13'd4088;
    localparam logic [H_W-1:0] H_TOTAL_CAP  = 13'd4128;
    localparam logic [H_W-1:0] H_DISP_MIN   = 13'd640;
    localparam logic [H_W-1:0] H_DISP_WIDE  = 13'd2048;
    localparam logic [H_W-1:0] H_DISP_STD   = 13'd1920;
    localparam logic [H_W-1:0] H_BLANK_MIN  = 13'd80;
    localparam logic [H_W-1:0] H_STEP       = 13'd8;
    localparam logic [H_W-1:0] H_PULSE_MAX  = 13'h0f8;

    // vertical register caps
    localparam logic [V_W-1:0] V_DISP_CAP   = 12'h7fd;
    localparam logic [V_W-1:0] V_SSTART_CAP = 12'h7fe;
    localparam logic [V_W-1:0] V_SEND_CAP   = 12'h7ff;
    localparam logic [V_W-1:0] V_TOTAL_CAP  = 12'h801;
    localparam logic [V_W-1:0] V_DISP_MIN   = 12'd480;
    localparam logic [V_W-1:0] V_DISP_WIDE  = 12'd1536;
    localparam logic [V_W-1:0] V_DISP_STD   = 12'd1440;
    localparam logic [V_W-1:0] V_BLANK_MIN  = 12'd3;
    localparam logic [V_W-1:0] V_STEP       = 12'd1;
    localparam logic [V_W-1:0] V_PULSE_MAX  = 12'h00f;

    localparam logic WIDE_LIMITS_RESET = 1'b1;

    typedef struct packed {
        logic [IN_W-1:0] h_display_end;
        logic [IN_W-1:0] h_sync_lead;
        logic [IN_W-1:0] h_sync_trail;
        logic [IN_W-1:0] h_total;
        logic [IN_W-1:0] v_display_end;
        logic [IN_W-1:0] v_sync_lead;
        logic [IN_W-1:0] v_sync_trail;
        logic [IN_W-1:0] v_total;
    } t_mode_in;

    typedef struct packed {
        logic [H_W-1:0] h_display_end_out;
        logic [H_W-1:0] h_sync_lead_out;
        logic [H_W-1:0] h_sync_trail_out;
        logic [H_W-1:0] h_total_out;
        logic [V_W-1:0] v_display_end_out;
        logic [V_W-1:0] v_sync_lead_out;
        logic [V_W-1:0] v_sync_trail_out;
        logic [V_W-1:0] v_total_out;
    } t_mode_out;

endpackage

@@ design/video_mode_line_clamp.sv @@
// ----------------------------------------------------------------------------
// video_mode_line_clamp
// corrects a display mode line so that it fits the crtc timing registers
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid / o_stall / i_data carries one requested mode line
//   per transfer; output channel o_valid / i_stall / o_data returns the
//   corrected line. one result per input, in order.
//   i_cfg_we / i_cfg_data write the wide-limits bit (1 after reset); write it
//   only while no mode line is in flight.
// path: the input transfer fills the input register, then the clamp logic
//   writes the result register, which drives o_valid and o_data.
// throughput: one mode line per cycle while i_stall is low, set by the
//   single-pass clamp logic between the two registers.
// reset: both pipeline stages empty, o_valid low, o_stall low, wide limits on.
// stall: while i_stall holds a result, the input register still takes one
//   more line; o_stall rises only when both stages are full and the output
//   is stalled, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module video_mode_line_clamp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  vmlc_pkg::t_mode_in  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output vmlc_pkg::t_mode_out o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data
);

    logic                r_in_valid, r_out_valid, r_wide;
    vmlc_pkg::t_mode_in  r_in;
    vmlc_pkg::t_mode_out r_out, n_out;
    logic                out_ready, in_ready, in_xfer;

    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;
    assign in_xfer   = i_valid && in_ready;
    assign o_stall   = !in_ready;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    vmlc_h_clamp u_h_clamp (
        .i_display_end (r_in.h_display_end),
        .i_sync_start  (r_in.h_sync_lead),
        .i_sync_end    (r_in.h_sync_trail),
        .i_total       (r_in.h_total),
        .i_wide        (r_wide),
        .o_display_end (n_out.h_display_end_out),
        .o_sync_start  (n_out.h_sync_lead_out),
        .o_sync_end    (n_out.h_sync_trail_out),
        .o_total       (n_out.h_total_out)
    );

    vmlc_v_clamp u_v_clamp (
        .i_display_end (r_in.v_display_end),
        .i_sync_start  (r_in.v_sync_lead),
        .i_sync_end    (r_in.v_sync_trail),
        .i_total       (r_in.v_total),
        .i_wide        (r_wide),
        .o_display_end (n_out.v_display_end_out),
        .o_sync_start  (n_out.v_sync_lead_out),
        .o_sync_end    (n_out.v_sync_trail_out),
        .o_total       (n_out.v_total_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wide      <= vmlc_pkg::WIDE_LIMITS_RESET;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we) begin
                r_wide <= i_cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_data;
        end
        if (out_ready && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // an accepted line always lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_valid)
        else $error("accepted mode line not captured");

    // a waiting line moves on whenever the result register frees up
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_ready) |=> r_out_valid)
        else $error("mode line lost between stages");

    // delivered display size always within the configured bounds
    a_h_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.h_display_end_out >= vmlc_pkg::H_DISP_MIN) &&
                    (o_data.h_display_end_out <= (r_wide ? vmlc_pkg::H_DISP_WIDE
                                                         : vmlc_pkg::H_DISP_STD)))
        else $error("horizontal display end out of bounds");

    a_v_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.v_display_end_out >= vmlc_pkg::V_DISP_MIN) &&
                    (o_data.v_display_end_out <= (r_wide ? vmlc_pkg::V_DISP_WIDE
                                                         : vmlc_pkg::V_DISP_STD)))
        else $error("vertical display end out of bounds");

    // horizontal display end and total stay on the character grid
    a_h_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.h_display_end_out[2:0] == 3'b000) &&
                    (o_data.h_total_out[2:0] == 3'b000))
        else $error("horizontal timing off the character grid");

endmodule

@@ design/vmlc_h_clamp.sv @@
// ----------------------------------------------------------------------------
// vmlc_h_clamp
// horizontal timing correction: character alignment, caps and sync placement
// ----------------------------------------------------------------------------
module vmlc_h_clamp (
    input  logic [vmlc_pkg::IN_W-1:0] i_display_end,
    input  logic [vmlc_pkg::IN_W-1:0] i_sync_start,
    input  logic [vmlc_pkg::IN_W-1:0] i_sync_end,
    input  logic [vmlc_pkg::IN_W-1:0] i_total,
    input  logic                      i_wide,
    output logic [vmlc_pkg::H_W-1:0]  o_display_end,
    output logic [vmlc_pkg::H_W-1:0]  o_sync_start,
    output logic [vmlc_pkg::H_W-1:0]  o_sync_end,
    output logic [vmlc_pkg::H_W-1:0]  o_total
);

    logic [vmlc_pkg::IN_W-1:0] hd_a, hs_a, he_a, ht_a;
    logic [vmlc_pkg::H_W-1:0]  hd_c, hs_c, he_c, ht_c;
    logic [vmlc_pkg::H_W-1:0]  hd_f, hd_lim, hd;
    logic [vmlc_pkg::H_W-1:0]  ht_min, ht, he_max1, he1, hs_min, hs, he_max2;

    // drop the low three bits
    assign hd_a = {i_display_end[vmlc_pkg::IN_W-1:3], 3'b000};
    assign hs_a = {i_sync_start[vmlc_pkg::IN_W-1:3], 3'b000};
    assign he_a = {i_sync_end[vmlc_pkg::IN_W-1:3], 3'b000};
    assign ht_a = {i_total[vmlc_pkg::IN_W-1:3], 3'b000};

    always_comb begin
        hd_c = (hd_a > vmlc_pkg::IN_W'(vmlc_pkg::H_DISP_CAP))
             ? vmlc_pkg::H_DISP_CAP : hd_a[vmlc_pkg::H_W-1:0];
        hs_c = (hs_a > vmlc_pkg::IN_W'(vmlc_pkg::H_SSTART_CAP))
             ? vmlc_pkg::H_SSTART_CAP : hs_a[vmlc_pkg::H_W-1:0];
        he_c = (he_a > vmlc_pkg::IN_W'(vmlc_pkg::H_SEND_CAP))
             ? vmlc_pkg::H_SEND_CAP : he_a[vmlc_pkg::H_W-1:0];
        ht_c = (ht_a > vmlc_pkg::IN_W'(vmlc_pkg::H_TOTAL_CAP))
             ? vmlc_pkg::H_TOTAL_CAP : ht_a[vmlc_pkg::H_W-1:0];
    end

    always_comb begin
        hd_f   = (hd_c < vmlc_pkg::H_DISP_MIN) ? vmlc_pkg::H_DISP_MIN : hd_c;
        hd_lim = i_wide ? vmlc_pkg::H_DISP_WIDE : vmlc_pkg::H_DISP_STD;
        hd     = (hd_f > hd_lim) ? hd_lim : hd_f;

        ht_min  = hd + vmlc_pkg::H_BLANK_MIN;
        ht      = (ht_c < ht_min) ? ht_min : ht_c;
        // total is at least 720 here, no wrap
        he_max1 = ht - vmlc_pkg::H_STEP;
        he1     = (he_c > he_max1) ? he_max1 : he_c;
        hs_min  = hd + vmlc_pkg::H_STEP;
        hs      = (hs_c < hs_min) ? hs_min : hs_c;
        he_max2 = hs + vmlc_pkg::H_PULSE_MAX;
    end

    assign o_display_end = hd;
    assign o_sync_start  = hs;
    assign o_sync_end    = (he1 > he_max2) ? he_max2 : he1;
    assign o_total       = ht;

endmodule

@@ design/vmlc_v_clamp.sv @@
// ----------------------------------------------------------------------------
// vmlc_v_clamp
// vertical timing correction: caps and sync placement at line granularity
// ----------------------------------------------------------------------------
module vmlc_v_clamp (
    input  logic [vmlc_pkg::IN_W-1:0] i_display_end,
    input  logic [vmlc_pkg::IN_W-1:0] i_sync_start,
    input  logic [vmlc_pkg::IN_W-1:0] i_sync_end,
    input  logic [vmlc_pkg::IN_W-1:0] i_total,
    input  logic                      i_wide,
    output logic [vmlc_pkg::V_W-1:0]  o_display_end,
    output logic [vmlc_pkg::V_W-1:0]  o_sync_start,
    output logic [vmlc_pkg::V_W-1:0]  o_sync_end,
    output logic [vmlc_pkg::V_W-1:0]  o_total
);

    logic [vmlc_pkg::V_W-1:0] vd_c, vs_c, ve_c, vt_c;
    logic [vmlc_pkg::V_W-1:0] vd_f, vd_lim, vd;
    logic [vmlc_pkg::V_W-1:0] vt_min, vt, ve_max1, ve1, vs_min, vs, ve_max2;

    always_comb begin
        vd_c = (i_display_end > vmlc_pkg::IN_W'(vmlc_pkg::V_DISP_CAP))
             ? vmlc_pkg::V_DISP_CAP : i_display_end[vmlc_pkg::V_W-1:0];
        vs_c = (i_sync_start > vmlc_pkg::IN_W'(vmlc_pkg::V_SSTART_CAP))
             ? vmlc_pkg::V_SSTART_CAP : i_sync_start[vmlc_pkg::V_W-1:0];
        ve_c = (i_sync_end > vmlc_pkg::IN_W'(vmlc_pkg::V_SEND_CAP))
             ? vmlc_pkg::V_SEND_CAP : i_sync_end[vmlc_pkg::V_W-1:0];
        vt_c = (i_total > vmlc_pkg::IN_W'(vmlc_pkg::V_TOTAL_CAP))
             ? vmlc_pkg::V_TOTAL_CAP : i_total[vmlc_pkg::V_W-1:0];
    end

    always_comb begin
        vd_f   = (vd_c < vmlc_pkg::V_DISP_MIN) ? vmlc_pkg::V_DISP_MIN : vd_c;
        vd_lim = i_wide ? vmlc_pkg::V_DISP_WIDE : vmlc_pkg::V_DISP_STD;
        vd     = (vd_f > vd_lim) ? vd_lim : vd_f;

        vt_min  = vd + vmlc_pkg::V_BLANK_MIN;
        vt      = (vt_c < vt_min) ? vt_min : vt_c;
        ve_max1 = vt - vmlc_pkg::V_STEP;
        ve1     = (ve_c > ve_max1) ? ve_max1 : ve_c;
        vs_min  = vd + vmlc_pkg::V_STEP;
        vs      = (vs_c < vs_min) ? vs_min : vs_c;
        ve_max2 = vs + vmlc_pkg::V_PULSE_MAX;
    end

    assign o_display_end = vd;
    assign o_sync_start  = vs;
    assign o_sync_end    = (ve1 > ve_max2) ? ve_max2 : ve1;
    assign o_total       = vt;

endmodule

@@ sim/tb_video_mode_line_clamp.sv @@
// ----------------------------------------------------------------------------
// tb_video_mode_line_clamp
// self-checking bench for the mode line clamp
// ----------------------------------------------------------------------------
// Mode lines come from a queue and are offered with random gaps. Each transfer
// is scored against a clamp predictor at the current wide-limits setting.
// Corrected lines are taken under random back-pressure and compared field by
// field, oldest first. The run covers a directed set of corner lines under
// both limit settings. It then runs random phases with the setting alternated,
// one long output hold that fills the block, and one sender pause that lets
// the block drain.
// ----------------------------------------------------------------------------
module tb_video_mode_line_clamp;
    import vmlc_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int LONG_HOLD      = 64;
    localparam int PHASES         = 8;
    localparam int PHASE_LINES    = 200;
    localparam int REPORT_LIMIT   = 200;

    localparam logic [15:0] CORNERS [16] = '{
        16'h0000, 16'hffff, 16'd639,  16'd640,  16'd1920, 16'd2048, 16'd2056, 16'd4072,
        16'd4088, 16'd4128, 16'd479,  16'd1440, 16'd1536, 16'h07fd, 16'h07ff, 16'h0801
    };

    logic      i_clk;
    logic      i_rst_n    = 1'b0;
    logic      i_valid    = 1'b0;
    logic      o_stall;
    t_mode_in  i_data     = '0;
    logic      o_valid;
    logic      i_stall    = 1'b0;
    t_mode_out o_data;
    logic      i_cfg_we   = 1'b0;
    logic      i_cfg_data = 1'b0;

    t_mode_in  request_lines [$];
    t_mode_out due_lines [$];

    logic wide_setting = WIDE_LIMITS_RESET;
    logic tx_busy      = 1'b0;
    logic rx_busy      = 1'b0;
    logic in_taken     = 1'b0;
    logic out_taken    = 1'b0;
    int   send_wait    = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    int   hold_requests = 0;
    int   hold_served  = 0;
    int   items_queued   = 0;
    int   items_accepted = 0;
    int   lines_checked  = 0;
    int   config_writes  = 0;
    int   errors         = 0;

    video_mode_line_clamp i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    function automatic logic [15:0] cap_at(logic [15:0] v, logic [15:0] hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [15:0] raise_to(logic [15:0] v, logic [15:0] lo);
        return (v < lo) ? lo : v;
    endfunction

    function automatic t_mode_out clamp_mode_line(t_mode_in req, logic wide);
        logic [15:0] hd, hs, he, ht, vd, vs, ve, vt;
        t_mode_out fixed;
        // horizontal works in 8 pixel characters
        hd = cap_at(req.h_display_end & 16'hfff8, 16'(H_DISP_CAP));
        hs = cap_at(req.h_sync_lead   & 16'hfff8, 16'(H_SSTART_CAP));
        he = cap_at(req.h_sync_trail  & 16'hfff8, 16'(H_SEND_CAP));
        ht = cap_at(req.h_total       & 16'hfff8, 16'(H_TOTAL_CAP));
        hd = raise_to(hd, 16'(H_DISP_MIN));
        hd = cap_at(hd, wide ? 16'(H_DISP_WIDE) : 16'(H_DISP_STD));
        ht = raise_to(ht, hd + 16'(H_BLANK_MIN));
        he = cap_at(he, ht - 16'(H_STEP));
        hs = raise_to(hs, hd + 16'(H_STEP));
        he = cap_at(he, hs + 16'(H_PULSE_MAX));

        vd = cap_at(req.v_display_end, 16'(V_DISP_CAP));
        vs = cap_at(req.v_sync_lead,   16'(V_SSTART_CAP));
        ve = cap_at(req.v_sync_trail,  16'(V_SEND_CAP));
        vt = cap_at(req.v_total,       16'(V_TOTAL_CAP));
        vd = raise_to(vd, 16'(V_DISP_MIN));
        vd = cap_at(vd, wide ? 16'(V_DISP_WIDE) : 16'(V_DISP_STD));
        vt = raise_to(vt, vd + 16'(V_BLANK_MIN));
        ve = cap_at(ve, vt - 16'(V_STEP));
        vs = raise_to(vs, vd + 16'(V_STEP));
        ve = cap_at(ve, vs + 16'(V_PULSE_MAX));

        fixed.h_display_end_out = hd[H_W-1:0];
        fixed.h_sync_lead_out   = hs[H_W-1:0];
        fixed.h_sync_trail_out  = he[H_W-1:0];
        fixed.h_total_out       = ht[H_W-1:0];
        fixed.v_display_end_out = vd[V_W-1:0];
        fixed.v_sync_lead_out   = vs[V_W-1:0];
        fixed.v_sync_trail_out  = ve[V_W-1:0];
        fixed.v_total_out       = vt[V_W-1:0];
        return fixed;
    endfunction

    function automatic int draw_wait(logic busy);
        return busy ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic logic [15:0] corner_pick();
        return CORNERS[$urandom_range(0, 15)] + 16'($urandom_range(0, 7));
    endfunction

    function automatic t_mode_in random_mode_line();
        t_mode_in line;
        int hd, hs, he, ht, vd, vs, ve, vt;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            line = {$urandom, $urandom, $urandom, $urandom};
        end else if (kind < 9) begin
            // plausible timings around the width and height bounds
            hd = $urandom_range(560, 2200);
            hs = hd + int'($urandom_range(0, 120)) - 40;
            he = hs + int'($urandom_range(0, 320));
            ht = he + int'($urandom_range(0, 400)) - 120;
            vd = $urandom_range(440, 1600);
            vs = vd + int'($urandom_range(0, 12)) - 4;
            ve = vs + int'($urandom_range(0, 24));
            vt = ve + int'($urandom_range(0, 60)) - 15;
            line = {16'(hd), 16'(hs), 16'(he), 16'(ht), 16'(vd), 16'(vs), 16'(ve), 16'(vt)};
        end else begin
            line = {corner_pick(), corner_pick(), corner_pick(), corner_pick(),
                    corner_pick(), corner_pick(), corner_pick(), corner_pick()};
        end
        return line;
    endfunction

    task automatic queue_line(t_mode_in line);
        request_lines.push_back(line);
        items_queued++;
    endtask

    task automatic push_line(int hd, int hs, int he, int ht, int vd, int vs, int ve, int vt);
        queue_line({16'(hd), 16'(hs), 16'(he), 16'(ht), 16'(vd), 16'(vs), 16'(ve), 16'(vt)});
    endtask

    task automatic push_directed_set();
        push_line(0, 0, 0, 0, 0, 0, 0, 0);
        push_line(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  16'hffff, 16'hffff, 16'hffff, 16'hffff);
        push_line(16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa,
                  16'haaaa, 16'haaaa, 16'haaaa, 16'haaaa);
        push_line(16'h5555, 16'h5555, 16'h5555, 16'h5555,
                  16'h5555, 16'h5555, 16'h5555, 16'h5555);
        push_line(647, 663, 759, 807, 480, 490, 492, 525);
        push_line(1920, 2008, 2052, 2576, 1440, 1441, 1444, 1500);
        push_line(2048, 2104, 2152, 2800, 1536, 1537, 1540, 1600);
        push_line(2056, 2063, 2100, 2300, 1537, 1540, 1545, 1600);
        // sync start past the total is left where it is
        push_line(800, 4000, 4088, 1000, 600, 2000, 2047, 700);
        // sync end before sync start, total short of the blanking minimum
        push_line(1024, 1100, 900, 1050, 768, 780, 770, 790);
        // pulse longer than allowed
        push_line(1024, 1048, 1400, 1600, 768, 771, 800, 820);
        push_line(4080, 4088, 4096, 4136, 16'h07fe, 16'h07ff, 16'h0800, 16'h0802);
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || due_lines.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_wide(logic value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        wide_setting = value;
        config_writes++;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // input driver: a held line stays put until its transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_wait <= 0;
        end else if (!i_valid || in_taken) begin
            if (send_wait != 0) begin
                i_valid   <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (request_lines.size() != 0) begin
                i_data    <= request_lines.pop_front();
                i_valid   <= 1'b1;
                send_wait <= draw_wait(tx_busy);
            end else begin
                i_valid   <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge i_clk) begin : rx_pressure
        int n;
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
            hold_served <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            i_stall     <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (out_taken) begin
            n = draw_wait(rx_busy);
            stall_left <= (n > 0) ? n - 1 : 0;
            i_stall    <= (n != 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_mode_out want;
        in_taken  <= i_rst_n && i_valid && !o_stall;
        out_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (due_lines.size() == 0) begin
                    errors++;
                    $display("%0t: corrected line with none expected, actual %h",
                             $time, o_data);
                end else begin
                    want = due_lines.pop_front();
                    check_field("h_display_end", 16'(want.h_display_end_out),
                                16'(o_data.h_display_end_out));
                    check_field("h_sync_lead",   16'(want.h_sync_lead_out),
                                16'(o_data.h_sync_lead_out));
                    check_field("h_sync_trail",  16'(want.h_sync_trail_out),
                                16'(o_data.h_sync_trail_out));
                    check_field("h_total",       16'(want.h_total_out),
                                16'(o_data.h_total_out));
                    check_field("v_display_end", 16'(want.v_display_end_out),
                                16'(o_data.v_display_end_out));
                    check_field("v_sync_lead",   16'(want.v_sync_lead_out),
                                16'(o_data.v_sync_lead_out));
                    check_field("v_sync_trail",  16'(want.v_sync_trail_out),
                                16'(o_data.v_sync_trail_out));
                    check_field("v_total",       16'(want.v_total_out),
                                16'(o_data.v_total_out));
                    lines_checked++;
                end
            end
            if (i_valid && !o_stall) begin
                due_lines.push_back(clamp_mode_line(i_data, wide_setting));
                items_accepted++;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_wide(1'b1);
        @(posedge i_clk);
        push_directed_set();
        wait_idle();
        write_wide(1'b0);
        @(posedge i_clk);
        push_directed_set();
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_wide(p[0]);
            @(posedge i_clk);
            tx_busy = (p == 2) || ($urandom_range(0, 3) == 0);
            rx_busy = (p != 2) && ($urandom_range(0, 3) == 0);
            // long output hold while lines keep coming, so the block backs up
            if (p == 2)
                hold_requests++;
            if (p == 5) begin
                for (int k = 0; k < PHASE_LINES / 2; k++)
                    queue_line(random_mode_line());
                // sender pause until the block has drained
                wait_idle();
                @(posedge i_clk);
                for (int k = 0; k < PHASE_LINES / 2; k++)
                    queue_line(random_mode_line());
            end else begin
                for (int k = 0; k < PHASE_LINES; k++)
                    queue_line(random_mode_line());
            end
            wait_idle();
        end

        repeat (8) @(negedge i_clk);
        $display("mode lines sent %0d, corrected lines checked %0d, mismatches %0d",
                 items_queued, lines_checked, errors);
        $display("wide limits written %0d times across both settings, with a long output hold",
                 config_writes);
        if (errors == 0 && due_lines.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
